// ===== src/bat_pkg.sv =====
`timescale 1ns / 1ps
// Shared codes and types for the bounded array table.
// Used by the controller, the storage cells, the top level and the checker.
package bat_pkg;

	localparam int DEFAULT_CAPACITY = 16;

	localparam logic [2:0] F_CLEAR  = 3'd0;
	localparam logic [2:0] F_APPEND = 3'd1;
	localparam logic [2:0] F_READ   = 3'd2;
	localparam logic [2:0] F_INSPOS = 3'd3;
	localparam logic [2:0] F_DELPOS = 3'd4;
	localparam logic [2:0] F_SORTED = 3'd5;
	localparam logic [2:0] F_DELVAL = 3'd6;
	localparam logic [2:0] F_UNUSED = 3'd7;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BADPOS   = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic load;
		logic shift;
		logic ins;
		logic del;
	} bat_cell_ctl_t;

endpackage

// ===== src/bat_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the table chain: a stored word and a probe word.
// Depends on bat_pkg for the cell control struct.
module bat_cell
	import bat_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY,
	parameter int J = 0,
	localparam int IW = $clog2(CAPACITY)
) (
	input  logic          clk,
	input  bat_cell_ctl_t ctl,
	input  logic [IW-1:0] idx,
	input  logic [31:0]   val,
	input  logic [31:0]   left_entry,
	input  logic [31:0]   right_entry,
	input  logic [31:0]   right_probe,
	output logic [31:0]   entry,
	output logic [31:0]   probe
);

	localparam logic [IW-1:0] JI = IW'(J);

	logic [31:0] entry_q;
	logic [31:0] probe_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (JI > idx) begin
				entry_q <= left_entry;
			end else if (JI == idx) begin
				entry_q <= val;
			end
		end else if (ctl.del) begin
			if (JI >= idx) begin
				entry_q <= right_entry;
			end
		end
		if (ctl.load) begin
			probe_q <= entry_q;
		end else if (ctl.shift) begin
			probe_q <= right_probe;
		end
	end

	assign entry = entry_q;
	assign probe = probe_q;

endmodule

// ===== src/bat_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the bounded array table: checks, scans the probe chain and
// issues load, shift, insert and delete commands to the cells. Depends on bat_pkg.
module bat_ctrl
	import bat_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY,
	localparam int IW = $clog2(CAPACITY),
	localparam int FW = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [2:0]    func,
	input  logic [4:0]    position,
	input  logic [31:0]   value,
	input  logic [31:0]   head,
	output logic          busy,
	output bat_cell_ctl_t ctl,
	output logic [IW-1:0] cidx,
	output logic [31:0]   cval,
	output logic          done,
	output logic [2:0]    status,
	output logic [31:0]   data_out,
	output logic [4:0]    count
);

	localparam int CW = ((FW > 5) ? FW : 5) + 1;
	localparam logic [FW-1:0] FULL = FW'(CAPACITY);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic          state_q;
	logic [FW-1:0] fill_q;
	logic [2:0]    op_q;
	logic [31:0]   val_q;
	logic [IW-1:0] tgt_q;
	logic [IW-1:0] k_q;
	logic [IW-1:0] last_q;
	logic          done_q;
	logic [2:0]    status_q;
	logic [31:0]   data_q;

	logic          accept;
	logic [CW-1:0] fill_c;
	logic [CW-1:0] pos_c;
	logic          full;
	logic          empty;
	logic          bad_rd;
	logic          bad_ins;
	logic          fin;
	logic          scan;
	logic [2:0]    st_n;
	logic [31:0]   dat_n;
	logic [FW-1:0] fill_n;
	logic [IW-1:0] last_n;
	logic [IW-1:0] kp1;
	logic          at_tgt;
	logic          at_end;
	logic          le;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign fill_c  = CW'(fill_q);
	assign pos_c   = CW'(position);
	assign full    = (fill_q == FULL);
	assign empty   = (fill_q == '0);
	assign bad_rd  = (pos_c == '0) || (pos_c > fill_c);
	assign bad_ins = (pos_c == '0) || (pos_c > fill_c + CW'(1));
	assign kp1     = k_q + IW'(1);
	assign at_tgt  = (k_q == tgt_q);
	assign at_end  = (FW'(k_q) == fill_q - FW'(1));
	assign le      = ($signed(head) <= $signed(val_q));
	assign cval    = busy ? val_q : value;

	always_comb begin
		ctl    = '0;
		cidx   = '0;
		fin    = 1'b0;
		scan   = 1'b0;
		st_n   = ST_OK;
		dat_n  = '0;
		fill_n = fill_q;
		last_n = last_q;
		if (state_q == S_IDLE) begin
			if (accept) begin
				case (func)
					F_CLEAR: begin
						fill_n = '0;
						fin    = 1'b1;
					end
					F_APPEND: begin
						fin = 1'b1;
						if (full) begin
							st_n = ST_FULL;
						end else begin
							ctl.ins = 1'b1;
							cidx    = fill_q[IW-1:0];
							fill_n  = fill_q + FW'(1);
						end
					end
					F_READ, F_DELPOS, F_DELVAL: begin
						if (empty) begin
							fin  = 1'b1;
							st_n = ST_EMPTY;
						end else if (bad_rd && func != F_DELVAL) begin
							fin  = 1'b1;
							st_n = ST_BADPOS;
						end else begin
							scan     = 1'b1;
							ctl.load = 1'b1;
						end
					end
					F_INSPOS: begin
						fin = 1'b1;
						if (bad_ins) begin
							st_n = ST_BADPOS;
						end else if (full) begin
							st_n = ST_FULL;
						end else begin
							ctl.ins = 1'b1;
							cidx    = IW'(pos_c - CW'(1));
							fill_n  = fill_q + FW'(1);
						end
					end
					F_SORTED: begin
						if (full) begin
							fin  = 1'b1;
							st_n = ST_FULL;
						end else if (empty) begin
							fin     = 1'b1;
							ctl.ins = 1'b1;
							fill_n  = fill_q + FW'(1);
						end else begin
							scan     = 1'b1;
							ctl.load = 1'b1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
		end else begin
			ctl.shift = 1'b1;
			case (op_q)
				F_READ: begin
					if (at_tgt) begin
						fin   = 1'b1;
						dat_n = head;
					end
				end
				F_DELPOS: begin
					if (at_tgt) begin
						fin     = 1'b1;
						dat_n   = head;
						ctl.del = 1'b1;
						cidx    = k_q;
						fill_n  = fill_q - FW'(1);
					end
				end
				F_DELVAL: begin
					if (head == val_q) begin
						fin     = 1'b1;
						dat_n   = head;
						ctl.del = 1'b1;
						cidx    = k_q;
						fill_n  = fill_q - FW'(1);
					end else if (at_end) begin
						fin  = 1'b1;
						st_n = ST_NOTFOUND;
					end
				end
				F_SORTED: begin
					if (le) begin
						last_n = kp1;
					end
					if (at_end) begin
						fin     = 1'b1;
						ctl.ins = 1'b1;
						cidx    = le ? kp1 : last_q;
						fill_n  = fill_q + FW'(1);
					end
				end
				default: begin
					fin = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			done_q  <= 1'b0;
			k_q     <= '0;
			last_q  <= '0;
		end else begin
			done_q <= fin;
			fill_q <= fill_n;
			if (state_q == S_IDLE) begin
				k_q    <= '0;
				last_q <= '0;
				if (scan) begin
					state_q <= S_SCAN;
				end
			end else begin
				k_q    <= kp1;
				last_q <= last_n;
				if (fin) begin
					state_q <= S_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= func;
			val_q <= value;
			tgt_q <= IW'(pos_c - CW'(1));
		end
		if (fin) begin
			status_q <= st_n;
			data_q   <= dat_n;
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign data_out = data_q;
	assign count    = fill_c[4:0];

endmodule

// ===== src/bounded_array_table.sv =====
`timescale 1ns / 1ps
// Bounded array table: a chain of CAPACITY cells holding a packed word list.
// Clear, append, insert at position, sorted insert into an empty table and failed checks
// need no probe walk; read and delete at position walk to the position, delete value to the
// match (or the end if none matches), sorted insert the whole list, one cell a cycle. Busy
// falls as the result is strobed, so the next request can be taken in that cycle; results
// cannot be held off. Asynchronous reset empties count and control, not the words.
module bounded_array_table
	import bat_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [4:0]  position,
	input  logic [31:0] value,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] data_out,
	output logic [4:0]  count
);

	localparam int IW = $clog2(CAPACITY);

	bat_cell_ctl_t ctl;
	logic [IW-1:0] cidx;
	logic [31:0]   cval;
	logic [31:0]   entry_w [CAPACITY];
	logic [31:0]   probe_w [CAPACITY];

	bat_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.func     (func),
		.position (position),
		.value    (value),
		.head     (probe_w[0]),
		.busy     (busy),
		.ctl      (ctl),
		.cidx     (cidx),
		.cval     (cval),
		.done     (done),
		.status   (status),
		.data_out (data_out),
		.count    (count)
	);

	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		logic [31:0] left_w;
		logic [31:0] right_w;
		logic [31:0] rprobe_w;
		if (j == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid
			assign left_w = entry_w[j-1];
		end
		if (j == CAPACITY - 1) begin : g_last
			assign right_w  = entry_w[j];
			assign rprobe_w = '0;
		end else begin : g_inner
			assign right_w  = entry_w[j+1];
			assign rprobe_w = probe_w[j+1];
		end
		bat_cell #(.CAPACITY(CAPACITY), .J(j)) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.idx         (cidx),
			.val         (cval),
			.left_entry  (left_w),
			.right_entry (right_w),
			.right_probe (rprobe_w),
			.entry       (entry_w[j]),
			.probe       (probe_w[j])
		);
	end

endmodule

// ===== src/bat_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the bounded array table, attached by bind.
// Depends on bat_pkg for operation and status codes.
module bat_checker
	import bat_pkg::*;
#(
	parameter int CAPACITY = DEFAULT_CAPACITY
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  func,
	input logic        done,
	input logic [2:0]  status,
	input logic [31:0] data_out,
	input logic [4:0]  count
);

	localparam logic [4:0] CAP5 = 5'(CAPACITY % 32);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is still in progress");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == F_CLEAR) |=> (done && count == 5'd0 && status == ST_OK))
		else $error("clear did not complete in one cycle with an empty table");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (data_out == 32'd0))
		else $error("failed request returned a nonzero data word");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count == CAP5))
		else $error("full status with a count below capacity");

endmodule

bind bounded_array_table bat_checker #(.CAPACITY(CAPACITY)) u_bat_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.func     (func),
	.done     (done),
	.status   (status),
	.data_out (data_out),
	.count    (count)
);
